@@ src/assert_macros.svh @@
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define PSA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define PSA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/psa_pkg.sv @@
// Types and constants of the per-frame bitmap sub-allocator.
package psa_pkg;

  localparam int SIZE_W    = 32;
  localparam int PSIZE_W   = 17;
  localparam int PPN_W     = 7;
  localparam int OFF_W     = 22;
  localparam int STATUS_W  = 2;
  localparam int ONODE_W   = 2;
  localparam int PROD_W    = 24;
  localparam int QUO_W     = 6;
  localparam int STEP_W    = 3;
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [PSIZE_W-1:0] PART_SIZE_RST = 17'd256;
  localparam logic [PPN_W-1:0]   PPN_RST       = 7'd64;
  localparam logic [PPN_W-1:0]   PPN_MIN       = 7'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANT  = 2'd0,
    ST_NOROOM = 2'd1,
    ST_TOOBIG = 2'd2,
    ST_FRAME  = 2'd3
  } status_e;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FRAME = 1'b1
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PART_SIZE      = 1'b0,
    REG_PARTS_PER_NODE = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_LIMIT,
    SEQ_CMP,
    SEQ_DIV,
    SEQ_READ,
    SEQ_CHECK,
    SEQ_OFFSET,
    SEQ_DONE
  } seq_state_e;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV_STEP
  } alu_op_e;

  typedef struct packed {
    alu_op_e            op;
    logic [PPN_W-1:0]   mul_a;
    logic [PROD_W-1:0]  rem;
    logic [STEP_W-1:0]  step;
  } alu_req_t;

  typedef struct packed {
    logic [PROD_W-1:0] prod;
    logic              ge;
    logic [PROD_W-1:0] diff;
  } alu_rsp_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_en;
  } mem_ctl_t;

endpackage

@@ src/psa_alu.sv @@
// Shared arithmetic unit: a 7x17 multiply or one restoring-division step.
module psa_alu (
  input  psa_pkg::alu_req_t               req_i,
  input  logic [psa_pkg::PSIZE_W-1:0]     part_size_i,
  output psa_pkg::alu_rsp_t               rsp_o
);

  logic [psa_pkg::PROD_W-1:0] divisor;

  // The divisor is the part size shifted up to the current quotient bit.
  assign divisor = psa_pkg::PROD_W'(part_size_i) << req_i.step;

  always_comb begin
    rsp_o = '0;
    case (req_i.op)
      psa_pkg::ALU_MUL: begin
        rsp_o.prod = psa_pkg::PROD_W'(req_i.mul_a) * psa_pkg::PROD_W'(part_size_i);
      end
      psa_pkg::ALU_DIV_STEP: begin
        rsp_o.ge   = (req_i.rem >= divisor);
        rsp_o.diff = req_i.rem - divisor;
      end
      default: begin
        rsp_o = '0;
      end
    endcase
  end

endmodule

@@ src/psa_fit.sv @@
// First-fit search of a run of free parts in one node bitmap.
module psa_fit #(
  parameter int PARTS = 64
) (
  input  logic [PARTS-1:0]                bmap_i,
  input  logic [psa_pkg::PPN_W-1:0]       run_len_i,
  input  logic [psa_pkg::PPN_W-1:0]       parts_i,
  output logic                            found_o,
  output logic [$clog2(PARTS)-1:0]        start_o,
  output logic [PARTS-1:0]                bmap_o
);

  localparam int IW = $clog2(PARTS);

  logic [PARTS-1:0] run;
  logic [PARTS-1:0] fits;

  always_comb begin
    for (int j = 0; j < PARTS; j++) begin
      run[j] = (psa_pkg::PPN_W'(j) < run_len_i);
    end
  end

  // Every start position is checked on its own; the run must end within the node.
  always_comb begin
    for (int i = 0; i < PARTS; i++) begin
      fits[i] = ((bmap_i & (run << i)) == '0) &&
                ((8'(i) + 8'(run_len_i)) <= 8'(parts_i));
    end
  end

  always_comb begin
    start_o = '0;
    for (int i = PARTS - 1; i >= 0; i--) begin
      if (fits[i]) begin
        start_o = IW'(i);
      end
    end
  end

  assign found_o = |fits;
  assign bmap_o  = bmap_i | (run << start_o);

endmodule

@@ src/psa_bmap_mem.sv @@
// Node bitmap memory with per-entry valid bits that reset and frame clears drop.
module psa_bmap_mem #(
  parameter int FRAMES = 2,
  parameter int NODES  = 4,
  parameter int PARTS  = 64
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  psa_pkg::mem_ctl_t                      ctl_i,
  input  logic [(FRAMES > 1 ? $clog2(FRAMES) : 1)-1:0] frame_i,
  input  logic [(FRAMES > 1 ? $clog2(FRAMES) : 1)-1:0] clr_frame_i,
  input  logic [(NODES > 1 ? $clog2(NODES) : 1)-1:0]   rd_node_i,
  input  logic [(NODES > 1 ? $clog2(NODES) : 1)-1:0]   wr_node_i,
  input  logic [PARTS-1:0]                       wr_data_i,
  output logic [PARTS-1:0]                       rd_data_o
);

  localparam int DEPTH = FRAMES * NODES;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int FW    = FRAMES > 1 ? $clog2(FRAMES) : 1;
  localparam int NW    = NODES > 1 ? $clog2(NODES) : 1;

  logic [PARTS-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [PARTS-1:0] rd_data_q;
  logic             rd_vld_q;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;

  function automatic logic [AW-1:0] slot(input logic [FW-1:0] f, input logic [NW-1:0] n);
    slot = AW'(AW'(f) * AW'(NODES) + AW'(n));
  endfunction

  assign rd_addr = slot(frame_i, rd_node_i);
  assign wr_addr = slot(frame_i, wr_node_i);

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctl_i.rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
      end
      if (ctl_i.wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (ctl_i.clr_en) begin
        for (int n = 0; n < NODES; n++) begin
          vld_q[slot(clr_frame_i, NW'(n))] <= 1'b0;
        end
      end
    end
  end

  // An entry never written since its frame was entered reads as all parts free.
  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

@@ src/per_frame_bitmap_suballocator_core.sv @@
// Top level of the per-frame bitmap sub-allocator: sequencer, registers and stream ports.
// Takes one item at a time and gives one result beat for each. A begin-frame item
// goes from accept straight to the result state. An allocation first checks the request
// against parts_per_node times part_size with the shared multiplier, then works out
// the part count on the same unit one quotient bit per cycle, then reads one node
// bitmap per cycle until a node fits; a zero-byte request goes straight to the result,
// and one larger than a node goes there right after the size check. The next item is
// taken the cycle after the result lands in the output register, even while that beat
// still waits for m_axis_tready_i. Node bitmaps start free after reset with no clearing
// pass, and entering a frame frees that frame's nodes at once.
module per_frame_bitmap_suballocator_core #(
  parameter int FRAMES = 2,
  parameter int NODES  = 4,
  parameter int PARTS  = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [psa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [psa_pkg::PSIZE_W-1:0]       cfg_data_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [psa_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,  // [31:0] alloc_size
  input  logic                              s_axis_tuser_i,  // [0] mode
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [psa_pkg::M_TDATA_W-1:0]     m_axis_tdata_o,
  // [1:0] node_index, [23:2] byte_offset, [24] frame_index, [31:25] zero
  output logic [psa_pkg::STATUS_W-1:0]      m_axis_tuser_o   // [1:0] status
);

  localparam int FW = FRAMES > 1 ? $clog2(FRAMES) : 1;
  localparam int NW = NODES > 1 ? $clog2(NODES) : 1;
  localparam int IW = $clog2(PARTS);
  localparam logic [psa_pkg::PPN_W-1:0] PARTS_MAX = psa_pkg::PPN_W'(PARTS);
  localparam logic [FW-1:0]             FRAME_LAST = FW'(FRAMES - 1);
  localparam logic [NW-1:0]             NODE_LAST  = NW'(NODES - 1);

  psa_pkg::seq_state_e state_q, state_d;

  logic [psa_pkg::PSIZE_W-1:0] part_size_q;
  logic [psa_pkg::PPN_W-1:0]   ppn_q;
  logic [psa_pkg::PSIZE_W-1:0] eff_ps;
  logic [psa_pkg::PPN_W-1:0]   eff_ppn;

  logic [FW-1:0]                 frame_q, frame_d;
  logic [NW-1:0]                 node_q, node_d;
  logic [psa_pkg::SIZE_W-1:0]    size_q, size_d;
  logic [psa_pkg::PROD_W-1:0]    prod_q, prod_d;
  logic [psa_pkg::PROD_W-1:0]    rem_q, rem_d;
  logic [psa_pkg::QUO_W-1:0]     quo_q, quo_d, quo_nxt;
  logic [psa_pkg::STEP_W-1:0]    step_q, step_d;
  logic [psa_pkg::PPN_W-1:0]     run_q, run_d;
  logic [IW-1:0]                 start_q, start_d;

  psa_pkg::status_e              res_status_q, res_status_d;
  logic [psa_pkg::ONODE_W-1:0]   res_node_q, res_node_d;
  logic [psa_pkg::OFF_W-1:0]     res_off_q, res_off_d;

  logic                          out_valid_q, out_valid_d;
  logic                          out_load;
  psa_pkg::status_e              out_status_q;
  logic [psa_pkg::ONODE_W-1:0]   out_node_q;
  logic [psa_pkg::OFF_W-1:0]     out_off_q;
  logic                          out_frame_q;

  psa_pkg::alu_req_t alu_req;
  psa_pkg::alu_rsp_t alu_rsp;

  psa_pkg::mem_ctl_t mem_ctl;
  logic [NW-1:0]     rd_node;
  logic [PARTS-1:0]  rd_bmap;
  logic              fit_found;
  logic [IW-1:0]     fit_start;
  logic [PARTS-1:0]  fit_bmap;

  logic in_accept;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == psa_pkg::SEQ_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  assign eff_ps  = (part_size_q == '0) ? psa_pkg::PSIZE_W'(1) : part_size_q;
  assign eff_ppn = (ppn_q < psa_pkg::PPN_MIN) ? psa_pkg::PPN_MIN :
                   (ppn_q > PARTS_MAX) ? PARTS_MAX : ppn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_size_q <= psa_pkg::PART_SIZE_RST;
      ppn_q       <= psa_pkg::PPN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (psa_pkg::reg_idx_e'(cfg_index_i))
        psa_pkg::REG_PART_SIZE:      part_size_q <= cfg_data_i;
        psa_pkg::REG_PARTS_PER_NODE: ppn_q       <= cfg_data_i[psa_pkg::PPN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  psa_alu u_alu (
    .req_i       (alu_req),
    .part_size_i (eff_ps),
    .rsp_o       (alu_rsp)
  );

  psa_bmap_mem #(
    .FRAMES (FRAMES),
    .NODES  (NODES),
    .PARTS  (PARTS)
  ) u_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (mem_ctl),
    .frame_i     (frame_q),
    .clr_frame_i (frame_d),
    .rd_node_i   (rd_node),
    .wr_node_i   (node_q),
    .wr_data_i   (fit_bmap),
    .rd_data_o   (rd_bmap)
  );

  psa_fit #(
    .PARTS (PARTS)
  ) u_fit (
    .bmap_i    (rd_bmap),
    .run_len_i (run_q),
    .parts_i   (eff_ppn),
    .found_o   (fit_found),
    .start_o   (fit_start),
    .bmap_o    (fit_bmap)
  );

  assign quo_nxt = alu_rsp.ge ? (quo_q | (psa_pkg::QUO_W'(1) << step_q)) : quo_q;
  assign out_load = (state_q == psa_pkg::SEQ_DONE) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    state_d      = state_q;
    frame_d      = frame_q;
    node_d       = node_q;
    size_d       = size_q;
    prod_d       = prod_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    step_d       = step_q;
    run_d        = run_q;
    start_d      = start_q;
    res_status_d = res_status_q;
    res_node_d   = res_node_q;
    res_off_d    = res_off_q;
    alu_req      = '0;
    alu_req.op   = psa_pkg::ALU_DIV_STEP;
    mem_ctl      = '0;
    rd_node      = node_q;

    case (state_q)
      psa_pkg::SEQ_IDLE: begin
        if (in_accept) begin
          res_node_d = '0;
          res_off_d  = '0;
          if (psa_pkg::mode_e'(s_axis_tuser_i) == psa_pkg::MODE_FRAME) begin
            frame_d        = (frame_q == FRAME_LAST) ? '0 : frame_q + FW'(1);
            mem_ctl.clr_en = 1'b1;
            res_status_d   = psa_pkg::ST_FRAME;
            state_d        = psa_pkg::SEQ_DONE;
          end else if (s_axis_tdata_i == '0) begin
            res_status_d = psa_pkg::ST_GRANT;
            state_d      = psa_pkg::SEQ_DONE;
          end else begin
            size_d  = s_axis_tdata_i;
            state_d = psa_pkg::SEQ_LIMIT;
          end
        end
      end
      psa_pkg::SEQ_LIMIT: begin
        alu_req.op    = psa_pkg::ALU_MUL;
        alu_req.mul_a = eff_ppn;
        prod_d        = alu_rsp.prod;
        state_d       = psa_pkg::SEQ_CMP;
      end
      psa_pkg::SEQ_CMP: begin
        // The request fits a node exactly when it is no larger than the node in bytes.
        if (size_q > psa_pkg::SIZE_W'(prod_q)) begin
          res_status_d = psa_pkg::ST_TOOBIG;
          state_d      = psa_pkg::SEQ_DONE;
        end else begin
          rem_d   = psa_pkg::PROD_W'(size_q - psa_pkg::SIZE_W'(1));
          quo_d   = '0;
          step_d  = psa_pkg::STEP_W'(psa_pkg::QUO_W - 1);
          state_d = psa_pkg::SEQ_DIV;
        end
      end
      psa_pkg::SEQ_DIV: begin
        alu_req.rem  = rem_q;
        alu_req.step = step_q;
        if (alu_rsp.ge) begin
          rem_d = alu_rsp.diff;
        end
        quo_d = quo_nxt;
        if (step_q == '0) begin
          // Parts needed is the floor of (size - 1) / part_size, plus one.
          run_d   = psa_pkg::PPN_W'(quo_nxt) + psa_pkg::PPN_W'(1);
          node_d  = '0;
          state_d = psa_pkg::SEQ_READ;
        end else begin
          step_d = step_q - psa_pkg::STEP_W'(1);
        end
      end
      psa_pkg::SEQ_READ: begin
        mem_ctl.rd_en = 1'b1;
        state_d       = psa_pkg::SEQ_CHECK;
      end
      psa_pkg::SEQ_CHECK: begin
        if (fit_found) begin
          mem_ctl.wr_en = 1'b1;
          start_d       = fit_start;
          state_d       = psa_pkg::SEQ_OFFSET;
        end else if (node_q == NODE_LAST) begin
          res_status_d = psa_pkg::ST_NOROOM;
          state_d      = psa_pkg::SEQ_DONE;
        end else begin
          node_d        = node_q + NW'(1);
          rd_node       = node_d;
          mem_ctl.rd_en = 1'b1;
        end
      end
      psa_pkg::SEQ_OFFSET: begin
        alu_req.op    = psa_pkg::ALU_MUL;
        alu_req.mul_a = psa_pkg::PPN_W'(start_q);
        res_off_d     = alu_rsp.prod[psa_pkg::OFF_W-1:0];
        res_node_d    = psa_pkg::ONODE_W'(node_q);
        res_status_d  = psa_pkg::ST_GRANT;
        state_d       = psa_pkg::SEQ_DONE;
      end
      psa_pkg::SEQ_DONE: begin
        if (out_load) begin
          state_d = psa_pkg::SEQ_IDLE;
        end
      end
      default: begin
        state_d = psa_pkg::SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psa_pkg::SEQ_IDLE;
      frame_q <= '0;
    end else begin
      state_q <= state_d;
      frame_q <= frame_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q       <= node_d;
    size_q       <= size_d;
    prod_q       <= prod_d;
    rem_q        <= rem_d;
    quo_q        <= quo_d;
    step_q       <= step_d;
    run_q        <= run_d;
    start_q      <= start_d;
    res_status_q <= res_status_d;
    res_node_q   <= res_node_d;
    res_off_q    <= res_off_d;
  end

  // The output register frees the sequencer while a result beat waits downstream.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status_q;
      out_node_q   <= res_node_q;
      out_off_q    <= res_off_q;
      out_frame_q  <= frame_q[0];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {7'b0, out_frame_q, out_off_q, out_node_q};

endmodule

@@ src/psa_checker.sv @@
// Port-level checker of the sub-allocator, bound to its top level.
`include "assert_macros.svh"

module psa_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cfg_valid_i,
  input logic                              cfg_ready_o,
  input logic [psa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input logic [psa_pkg::PSIZE_W-1:0]       cfg_data_i,
  input logic                              s_axis_tvalid_i,
  input logic                              s_axis_tready_o,
  input logic [psa_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,
  input logic                              s_axis_tuser_i,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [psa_pkg::M_TDATA_W-1:0]     m_axis_tdata_o,
  input logic [psa_pkg::STATUS_W-1:0]      m_axis_tuser_o
);

  // The block works on one item at a time, so it is busy right after any accept.
  `PSA_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)

  // Every result other than a grant carries node zero and offset zero.
  `PSA_ASSERT_IMP(a_nogrant_zero, m_axis_tvalid_o && (m_axis_tuser_o != psa_pkg::ST_GRANT), m_axis_tdata_o[23:0] == 24'd0)

  `PSA_ASSERT_NXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))

endmodule

bind per_frame_bitmap_suballocator_core psa_checker u_psa_checker (.*);

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the per-frame bitmap sub-allocator core.
`timescale 1ns / 1ps

module testbench;
  import psa_pkg::*;

  localparam int FRAMES    = 2;
  localparam int NODES     = 4;
  localparam int PARTS     = 64;
  localparam int IDLE_MAX  = 5000;
  localparam int DRAIN_CYC = 40;
  localparam int PHASE_N   = 8;
  localparam int PHASE_ITEMS = 96;
  localparam int DIR_N     = 21;

  typedef struct packed {
    status_e           status;
    logic [1:0]        node;
    logic [OFF_W-1:0]  offset;
    logic              frame;
  } grant_t;

  typedef struct packed {
    mode_e             mode;
    logic [31:0]       size;
    logic              typed;
    grant_t            want;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  reg_idx_e             cfg_index = REG_PART_SIZE;
  logic [PSIZE_W-1:0]   cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [31:0]          s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [31:0]          m_tdata;
  logic [1:0]           m_tuser;

  // Shadow copy of the block state.
  int unsigned          cur_frame = 0;
  logic [63:0]          used_map [FRAMES*NODES];
  logic [PSIZE_W-1:0]   part_bytes = PART_SIZE_RST;
  logic [PPN_W-1:0]     node_parts = PPN_RST;

  grant_t               grant_q [$];
  int                   err_cnt = 0;
  int                   res_cnt = 0;
  int                   burst_left = 0;
  int unsigned          rx_cyc = 0;
  int                   hold_left = 0;
  int                   pat_mode = 0;
  int                   pat_left = 0;
  int                   idle_cnt = 0;

  always #5 clk_i = ~clk_i;

  per_frame_bitmap_suballocator_core #(
    .FRAMES(FRAMES),
    .NODES (NODES),
    .PARTS (PARTS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  function automatic int unsigned eff_bytes();
    return (part_bytes == '0) ? 1 : int'(part_bytes);
  endfunction

  function automatic int unsigned eff_parts();
    if (node_parts < PPN_MIN) return 2;
    if (node_parts > PARTS) return PARTS;
    return int'(node_parts);
  endfunction

  // First-fit search over the current frame, or a frame advance; updates the shadow bitmaps.
  function automatic grant_t next_grant(input mode_e mode, input logic [31:0] size);
    grant_t      res;
    logic [63:0] ps;
    logic [63:0] need;
    logic [63:0] run;
    logic [63:0] m;
    logic [63:0] off;
    int unsigned np;
    int unsigned r;
    int unsigned slot;
    res.status = ST_GRANT;
    res.node   = '0;
    res.offset = '0;
    if (mode == MODE_FRAME) begin
      cur_frame = (cur_frame + 1) % FRAMES;
      for (int n = 0; n < NODES; n++) used_map[cur_frame*NODES + n] = '0;
      res.status = ST_FRAME;
      res.frame  = cur_frame[0];
      return res;
    end
    res.frame = cur_frame[0];
    ps   = 64'(eff_bytes());
    np   = eff_parts();
    need = ({32'd0, size} + ps - 64'd1) / ps;
    if (need > 64'(np)) begin
      res.status = ST_TOOBIG;
      return res;
    end
    r = int'(need);
    if (r == 0) return res;
    run = (r >= 64) ? '1 : ((64'd1 << r) - 64'd1);
    for (int n = 0; n < NODES; n++) begin
      slot = cur_frame*NODES + n;
      for (int unsigned i = 0; i + r <= np; i++) begin
        m = run << i;
        if ((used_map[slot] & m) == '0) begin
          used_map[slot] = used_map[slot] | m;
          off = 64'(i) * ps;
          res.node   = n[1:0];
          res.offset = off[OFF_W-1:0];
          return res;
        end
      end
    end
    res.status = ST_NOROOM;
    return res;
  endfunction

  // Mostly sizes that round to a part count in or near the node range.
  function automatic logic [31:0] pick_size();
    logic [63:0] ps;
    logic [63:0] k;
    logic [63:0] sz;
    int unsigned np;
    int unsigned sel;
    ps  = 64'(eff_bytes());
    np  = eff_parts();
    sel = $urandom_range(0, 99);
    if (sel < 4) return '0;
    if (sel < 9) return $urandom;
    if (sel < 15) k = 64'(np + 1 + $urandom_range(0, 3));
    else if (sel < 55) k = 64'($urandom_range(1, (np/4 > 1) ? np/4 : 1));
    else k = 64'($urandom_range(1, np));
    sz = k * ps - 64'($urandom_range(0, int'(ps) - 1));
    return sz[31:0];
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch in result %0d, %s: got 0x%0h, expected 0x%0h",
             res_cnt, field, got, want);
    err_cnt++;
  endtask

  task automatic check_result();
    grant_t e;
    if (grant_q.size() == 0) begin
      report_mismatch("unexpected beat", {m_tuser, m_tdata[29:0]}, '0);
    end else begin
      e = grant_q.pop_front();
      if (m_tuser !== e.status) report_mismatch("status", 32'(m_tuser), 32'(e.status));
      if (m_tdata[1:0] !== e.node) report_mismatch("node_index", 32'(m_tdata[1:0]), 32'(e.node));
      if (m_tdata[23:2] !== e.offset)
        report_mismatch("byte_offset", 32'(m_tdata[23:2]), 32'(e.offset));
      if (m_tdata[24] !== e.frame) report_mismatch("frame_index", 32'(m_tdata[24]), 32'(e.frame));
      if (m_tdata[31:25] !== '0) report_mismatch("padding", 32'(m_tdata[31:25]), '0);
    end
    res_cnt++;
  endtask

  // Result side: check accepted beats, drive tready from a changing pattern.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      rx_cyc++;
      if (m_tvalid && m_tready) check_result();
      if (rx_cyc == 3000 || rx_cyc == 12000) hold_left = 400;
      if (pat_left == 0) begin
        pat_mode = $urandom_range(0, 3);
        pat_left = $urandom_range(32, 200);
      end else begin
        pat_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (pat_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= (rx_cyc % 4 == 0);
          default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_MAX) begin
      $display("watchdog: no handshake for %0d cycles, %0d results pending",
               IDLE_MAX, grant_q.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // Sender: offers beats in bursts separated by random gaps.
  task automatic send_beat(input mode_e mode, input logic [31:0] size, input logic typed,
                           input grant_t want);
    grant_t got;
    int     gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= size;
    s_tuser  <= mode;
    do @(posedge clk_i); while (!s_tready);
    got = next_grant(mode, size);
    grant_q.push_back(typed ? want : got);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [PSIZE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == REG_PART_SIZE) part_bytes = val;
    else node_parts = val[PPN_W-1:0];
  endtask

  task automatic set_layout(input logic [PSIZE_W-1:0] ps, input logic [PSIZE_W-1:0] ppn);
    write_reg(REG_PART_SIZE, ps);
    write_reg(REG_PARTS_PER_NODE, ppn);
    cfg_valid <= 1'b0;
  endtask

  // Runs under the reset layout of 256-byte parts, 64 parts per node.
  dir_row_t dir_tab [DIR_N] = '{
    '{MODE_ALLOC, 32'd0,          1'b1, '{ST_GRANT,  2'd0, 22'd0,   1'b0}},
    '{MODE_ALLOC, 32'd1,          1'b1, '{ST_GRANT,  2'd0, 22'd0,   1'b0}},
    '{MODE_ALLOC, 32'd256,        1'b1, '{ST_GRANT,  2'd0, 22'd256, 1'b0}},
    '{MODE_ALLOC, 32'd257,        1'b0, '{ST_GRANT,  2'd0, 22'd0,   1'b0}},
    '{MODE_ALLOC, 32'd16384,      1'b0, '{ST_GRANT,  2'd0, 22'd0,   1'b0}},
    '{MODE_ALLOC, 32'd16385,      1'b1, '{ST_TOOBIG, 2'd0, 22'd0,   1'b0}},
    '{MODE_ALLOC, 32'hFFFF_FFFF,  1'b1, '{ST_TOOBIG, 2'd0, 22'd0,   1'b0}},
    '{MODE_ALLOC, 32'h8000_0000,  1'b1, '{ST_TOOBIG, 2'd0, 22'd0,   1'b0}},
    '{MODE_FRAME, 32'h5A5A_A5A5,  1'b1, '{ST_FRAME,  2'd0, 22'd0,   1'b1}},
    '{MODE_ALLOC, 32'd16384,      1'b0, '{ST_GRANT,  2'd0, 22'd0,   1'b0}},
    '{MODE_ALLOC, 32'd16384,      1'b0, '{ST_GRANT,  2'd0, 22'd0,   1'b0}},
    '{MODE_ALLOC, 32'd16384,      1'b0, '{ST_GRANT,  2'd0, 22'd0,   1'b0}},
    '{MODE_ALLOC, 32'd16384,      1'b0, '{ST_GRANT,  2'd0, 22'd0,   1'b0}},
    '{MODE_ALLOC, 32'd1,          1'b0, '{ST_GRANT,  2'd0, 22'd0,   1'b0}},
    '{MODE_ALLOC, 32'd0,          1'b1, '{ST_GRANT,  2'd0, 22'd0,   1'b1}},
    '{MODE_FRAME, 32'd0,          1'b1, '{ST_FRAME,  2'd0, 22'd0,   1'b0}},
    '{MODE_ALLOC, 32'd16128,      1'b0, '{ST_GRANT,  2'd0, 22'd0,   1'b0}},
    '{MODE_ALLOC, 32'd512,        1'b0, '{ST_GRANT,  2'd0, 22'd0,   1'b0}},
    '{MODE_ALLOC, 32'd255,        1'b0, '{ST_GRANT,  2'd0, 22'd0,   1'b0}},
    '{MODE_FRAME, 32'hFFFF_FFFF,  1'b1, '{ST_FRAME,  2'd0, 22'd0,   1'b1}},
    '{MODE_ALLOC, 32'd1,          1'b0, '{ST_GRANT,  2'd0, 22'd0,   1'b0}}
  };

  // Part size, parts per node by phase, extremes and clamps; 5 and 7 are random.
  logic [PSIZE_W-1:0] phase_ps  [PHASE_N] = '{17'd256, 17'd1, 17'd65536, 17'd0,
                                              17'h1FFFF, 17'd0, 17'd48, 17'd0};
  logic [PSIZE_W-1:0] phase_ppn [PHASE_N] = '{17'd64, 17'd2, 17'd64, 17'd0,
                                              17'd127, 17'd0, 17'd1, 17'd0};

  initial begin
    mode_e       mode;
    logic [31:0] size;
    grant_t      none;
    none = '{ST_GRANT, 2'd0, 22'd0, 1'b0};
    for (int s = 0; s < FRAMES*NODES; s++) used_map[s] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int d = 0; d < DIR_N; d++)
      send_beat(dir_tab[d].mode, dir_tab[d].size, dir_tab[d].typed, dir_tab[d].want);

    for (int p = 0; p < PHASE_N; p++) begin
      wait_drained();
      if (p == 5) set_layout(17'($urandom_range(1, 4096)), 17'($urandom_range(2, 64)));
      else if (p == 7) set_layout(17'($urandom), 17'($urandom_range(0, 127)));
      else set_layout(phase_ps[p], phase_ppn[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        mode = ($urandom_range(0, 11) == 0) ? MODE_FRAME : MODE_ALLOC;
        size = (mode == MODE_FRAME) ? $urandom : pick_size();
        send_beat(mode, size, 1'b0, none);
      end
    end

    wait_drained();
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (err_cnt == 0 && grant_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
